// ===== rtl/cpu8_alu_register_execute_macros.svh =====
`ifndef CPU8_ALU_REGISTER_EXECUTE_MACROS_SVH
`define CPU8_ALU_REGISTER_EXECUTE_MACROS_SVH

// same-cycle implication
`define CPU8X_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpu8x check failed");

// next-cycle implication
`define CPU8X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpu8x check failed");

`endif

// ===== rtl/cpu8x_pkg.sv =====
package cpu8x_pkg;

    typedef enum logic [5:0] {
        OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
        OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
        OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
        OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_LDA = 6'd15,
        OP_LDX = 6'd16, OP_LDY = 6'd17, OP_STA = 6'd18, OP_STX = 6'd19,
        OP_STY = 6'd20, OP_TAX = 6'd21, OP_TXA = 6'd22, OP_TAY = 6'd23,
        OP_TYA = 6'd24, OP_INX = 6'd25, OP_DEX = 6'd26, OP_INY = 6'd27,
        OP_DEY = 6'd28, OP_CLC = 6'd29, OP_SEC = 6'd30, OP_CLI = 6'd31,
        OP_SEI = 6'd32, OP_CLV = 6'd33, OP_CLD = 6'd34, OP_SED = 6'd35,
        OP_NOP = 6'd36
    } op_t;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] status;
    } regs_t;

    typedef struct packed {
        logic [5:0] req_type;
        logic [7:0] operand;
        logic       on_accumulator;
    } item_t;

endpackage

// ===== rtl/cpu8x_alu.sv =====
module cpu8x_alu
    import cpu8x_pkg::*;
(
    input  item_t      item,
    input  regs_t      regs,
    output regs_t      regs_new,
    output logic [7:0] write_byte,
    output logic       write_enable
);

    op_t        op;
    logic [7:0] m_eff;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] cmp_reg;
    logic [7:0] sh_in;
    logic [7:0] sh_res;
    logic       sh_c;
    logic       cin;

    assign op  = op_t'(item.req_type);
    assign cin = regs.status[FLAG_C];

    always_comb
    begin
        logic [7:0] zn_val;
        logic       zn_en;

        regs_new     = regs;
        write_byte   = 8'h00;
        write_enable = 1'b0;
        zn_val       = 8'h00;
        zn_en        = 1'b0;

        m_eff = (op == OP_SBC) ? ~item.operand : item.operand;
        sum   = {1'b0, regs.acc} + {1'b0, m_eff} + {8'h00, cin};

        case (op)
            OP_CPX:  cmp_reg = regs.x;
            OP_CPY:  cmp_reg = regs.y;
            default: cmp_reg = regs.acc;
        endcase
        diff = {1'b0, cmp_reg} + {1'b0, ~item.operand} + 9'd1;

        sh_in = item.on_accumulator ? regs.acc : item.operand;
        case (op)
            OP_ASL:
            begin
                sh_c   = sh_in[7];
                sh_res = {sh_in[6:0], 1'b0};
            end
            OP_LSR:
            begin
                sh_c   = sh_in[0];
                sh_res = {1'b0, sh_in[7:1]};
            end
            OP_ROL:
            begin
                sh_c   = sh_in[7];
                sh_res = {sh_in[6:0], cin};
            end
            default:
            begin
                sh_c   = sh_in[0];
                sh_res = {cin, sh_in[7:1]};
            end
        endcase

        case (op)
            OP_ORA:
            begin
                regs_new.acc = regs.acc | item.operand;
                zn_val = regs_new.acc;
                zn_en  = 1'b1;
            end
            OP_AND:
            begin
                regs_new.acc = regs.acc & item.operand;
                zn_val = regs_new.acc;
                zn_en  = 1'b1;
            end
            OP_EOR:
            begin
                regs_new.acc = regs.acc ^ item.operand;
                zn_val = regs_new.acc;
                zn_en  = 1'b1;
            end
            OP_ADC, OP_SBC:
            begin
                regs_new.acc            = sum[7:0];
                regs_new.status[FLAG_C] = sum[8];
                regs_new.status[FLAG_V] = ~(regs.acc[7] ^ m_eff[7])
                                          & (regs.acc[7] ^ sum[7]);
                zn_val = sum[7:0];
                zn_en  = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                regs_new.status[FLAG_C] = diff[8];
                zn_val = diff[7:0];
                zn_en  = 1'b1;
            end
            OP_BIT:
            begin
                regs_new.status[FLAG_Z] = ((regs.acc & item.operand) == 8'h00);
                regs_new.status[FLAG_N] = item.operand[7];
                regs_new.status[FLAG_V] = item.operand[6];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                regs_new.status[FLAG_C] = sh_c;
                zn_val = sh_res;
                zn_en  = 1'b1;
                if (item.on_accumulator)
                begin
                    regs_new.acc = sh_res;
                end
                else
                begin
                    write_byte   = sh_res;
                    write_enable = 1'b1;
                end
            end
            OP_INC:
            begin
                write_byte   = item.operand + 8'd1;
                write_enable = 1'b1;
                zn_val = write_byte;
                zn_en  = 1'b1;
            end
            OP_DEC:
            begin
                write_byte   = item.operand - 8'd1;
                write_enable = 1'b1;
                zn_val = write_byte;
                zn_en  = 1'b1;
            end
            OP_LDA:
            begin
                regs_new.acc = item.operand;
                zn_val = item.operand;
                zn_en  = 1'b1;
            end
            OP_LDX:
            begin
                regs_new.x = item.operand;
                zn_val = item.operand;
                zn_en  = 1'b1;
            end
            OP_LDY:
            begin
                regs_new.y = item.operand;
                zn_val = item.operand;
                zn_en  = 1'b1;
            end
            OP_STA:
            begin
                write_byte   = regs.acc;
                write_enable = 1'b1;
            end
            OP_STX:
            begin
                write_byte   = regs.x;
                write_enable = 1'b1;
            end
            OP_STY:
            begin
                write_byte   = regs.y;
                write_enable = 1'b1;
            end
            OP_TAX:
            begin
                regs_new.x = regs.acc;
                zn_val = regs.acc;
                zn_en  = 1'b1;
            end
            OP_TXA:
            begin
                regs_new.acc = regs.x;
                zn_val = regs.x;
                zn_en  = 1'b1;
            end
            OP_TAY:
            begin
                regs_new.y = regs.acc;
                zn_val = regs.acc;
                zn_en  = 1'b1;
            end
            OP_TYA:
            begin
                regs_new.acc = regs.y;
                zn_val = regs.y;
                zn_en  = 1'b1;
            end
            OP_INX:
            begin
                regs_new.x = regs.x + 8'd1;
                zn_val = regs_new.x;
                zn_en  = 1'b1;
            end
            OP_DEX:
            begin
                regs_new.x = regs.x - 8'd1;
                zn_val = regs_new.x;
                zn_en  = 1'b1;
            end
            OP_INY:
            begin
                regs_new.y = regs.y + 8'd1;
                zn_val = regs_new.y;
                zn_en  = 1'b1;
            end
            OP_DEY:
            begin
                regs_new.y = regs.y - 8'd1;
                zn_val = regs_new.y;
                zn_en  = 1'b1;
            end
            OP_CLC: regs_new.status[FLAG_C] = 1'b0;
            OP_SEC: regs_new.status[FLAG_C] = 1'b1;
            OP_CLI: regs_new.status[FLAG_I] = 1'b0;
            OP_SEI: regs_new.status[FLAG_I] = 1'b1;
            OP_CLV: regs_new.status[FLAG_V] = 1'b0;
            OP_CLD: regs_new.status[FLAG_D] = 1'b0;
            OP_SED: regs_new.status[FLAG_D] = 1'b1;
            default: ;
        endcase

        if (zn_en)
        begin
            regs_new.status[FLAG_Z] = (zn_val == 8'h00);
            regs_new.status[FLAG_N] = zn_val[7];
        end
    end

endmodule

// ===== rtl/cpu8_alu_register_execute.sv =====
// An accepted item goes to the input register, its result to the result
// register. Throughput: one item per cycle unless a valid result stalls;
// the ALU sits between the two, and A, X, Y and status live in the latter.
// Reset: rst_n clears A, X, Y, status and both valid flags asynchronously.
module cpu8_alu_register_execute
    import cpu8x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [5:0] req_type,
    input  logic [7:0] operand,
    input  logic       on_accumulator,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] write_byte,
    output logic       write_enable,
    output logic [7:0] acc_out,
    output logic [7:0] x_out,
    output logic [7:0] y_out,
    output logic [7:0] status_out
);

    logic       item_valid_reg;
    logic       item_valid_next;
    item_t      item_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    regs_t      regs_reg;
    regs_t      regs_next;
    logic [7:0] wbyte_reg;
    logic [7:0] wbyte_next;
    logic       we_reg;
    logic       we_next;
    logic       advance;
    logic       req_take;

    assign advance   = item_valid_reg && !(rsp_valid_reg && rsp_stall);
    assign req_stall = item_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    cpu8x_alu u_alu (
        .item         (item_reg),
        .regs         (regs_reg),
        .regs_new     (regs_next),
        .write_byte   (wbyte_next),
        .write_enable (we_next)
    );

    always_comb
    begin
        item_valid_next = req_stall ? item_valid_reg : req_valid;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // hold the item while the result side is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            regs_reg       <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (advance)
            begin
                regs_reg <= regs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= '{req_type: req_type, operand: operand,
                          on_accumulator: on_accumulator};
        end
        if (advance)
        begin
            wbyte_reg <= wbyte_next;
            we_reg    <= we_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign write_byte   = wbyte_reg;
    assign write_enable = we_reg;
    assign acc_out      = regs_reg.acc;
    assign x_out        = regs_reg.x;
    assign y_out        = regs_reg.y;
    assign status_out   = regs_reg.status;

endmodule

// ===== rtl/cpu8x_checker.sv =====
`include "cpu8_alu_register_execute_macros.svh"

module cpu8x_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [7:0] acc_out,
    input logic [7:0] status_out
);

    `CPU8X_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(acc_out))
    `CPU8X_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)
    `CPU8X_ASSERT_NOW(a_status_fixed_bits, 1'b1, status_out[5:4] == 2'b00)
    `CPU8X_ASSERT_NOW(a_state_quiet, !rsp_valid && !req_stall && !req_valid, $stable(status_out))

endmodule

bind cpu8_alu_register_execute cpu8x_checker u_cpu8x_checker (.*);
